FILE: hw/rtl/unrg_pkg.sv
//------------------------------------------------------------------------------
// unrg_pkg
// Shared constants and state encoding for the random generator.
//------------------------------------------------------------------------------
`default_nettype none

package unrg_pkg;

    localparam int FRAC_BITS = 24;

    localparam logic [30:0] LCG_MUL = 31'd843314861;
    localparam logic [30:0] LCG_ADD = 31'd453816693;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UNI,
        ST_DRAW1,
        ST_DRAW2,
        ST_SQ1,
        ST_SQ2,
        ST_CHECK,
        ST_NORM,
        ST_LOG,
        ST_LOG_FIX,
        ST_SCALE,
        ST_SCALE_HI,
        ST_DIV,
        ST_SQRT,
        ST_MAG1,
        ST_MAG2,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/uniform_normal_random_generator.sv
// Flow from input transaction to o_valid: a uniform draw passes ST_UNI then
// ST_DONE; a cached normal spare goes straight to ST_DONE; a normal pair
// draws and squares a point (redrawn if rejected), then normalizes, takes the log, scales, divides, roots and finishes.
// Throughput: one transaction at a time; the next input is taken the cycle
// after the result is accepted. Synchronous active-low reset clears
// generator state, spare flag and control; seed writes load state.
//------------------------------------------------------------------------------
// uniform_normal_random_generator
// LCG uniform source with a polar-method normal path on one shared
// multiplier and a shift-subtract sequencer.
//------------------------------------------------------------------------------
`default_nettype none

module uniform_normal_random_generator
    import unrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seed_value_we,
    input  wire logic [30:0]        i_seed_value,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_normal_law,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_sample,
    output logic [30:0]             o_raw_state
);

    t_state r_state, n_state;

    logic [30:0]  r_lcg;
    logic         r_spare_held;
    logic [31:0]  r_spare;
    logic         r_ovalid;
    logic [31:0]  r_sample;

    logic [31:0]  r_a1, r_a2;     // magnitudes at 2^-31
    logic         r_n1, r_n2;
    logic [63:0]  r_acc;          // s, then general work
    logic [5:0]   r_k;
    logic [4:0]   r_cnt;
    logic [6:0]   r_it;
    logic [31:0]  r_yq;
    logic [31:0]  r_z;
    logic [29:0]  r_log;
    logic [63:0]  r_num;          // divide dividend/quotient
    logic [32:0]  r_rem;
    logic [63:0]  r_qv;
    logic [31:0]  r_sq;
    logic [33:0]  r_srem;
    logic [63:0]  r_prod;
    logic [5:0]   r_h;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic        in_acc;
    logic        out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_sample = r_sample;
    assign o_raw_state = r_lcg;

    logic [30:0] lcg_nx;
    assign lcg_nx = mul_p[30:0] + LCG_ADD;

    // signed draw helper
    logic [31:0] two_v, dmag;
    logic        dneg;
    always_comb begin
        two_v = {lcg_nx, 1'b0};
        dneg  = !two_v[31];
        dmag  = dneg ? (32'h8000_0000 - two_v) : (two_v - 32'h8000_0000);
    end

    // output sample builder from product and exponent
    function automatic logic [31:0] make_s(input logic [63:0] p, input logic neg,
                                           input logic [5:0] h);
        logic [6:0]  e;
        logic [63:0] m;
        logic [5:0]  sh;
        begin
            e = 7'(h) + 7'(FRAC_BITS) - 7'd55;
            m = '0;
            sh = '0;
            if (!e[6]) begin
                m = p << e[5:0];
            end else begin
                sh = 6'(-e);
                m = (p + (64'd1 << (sh - 6'd1))) >> sh;
            end
            if (neg) begin
                make_s = (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
            end else begin
                make_s = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
            end
        end
    endfunction

    // divide and root steps
    logic [33:0] dv_try;
    logic [33:0] sr_try;
    logic [33:0] sr_rem2;
    always_comb begin
        dv_try  = {r_rem, r_num[63]} - {2'b0, r_yq};
        sr_rem2 = {r_srem[31:0], r_qv[63:62]};
        sr_try  = sr_rem2 - {r_sq[31:0], 2'b01};
    end

    // log term and scaled product, low half held in r_prod
    logic [63:0] t_full;
    logic [63:0] a_q48;
    always_comb begin
        t_full = ({58'd0, r_k} << 30) - {34'd0, r_log};
        a_q48  = (r_prod + {mul_p[31:0], 32'd0}) >> 10;
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_UNI, ST_DRAW1, ST_DRAW2: begin
                mul_a = {1'b0, LCG_MUL};
                mul_b = {1'b0, r_lcg};
            end
            ST_SQ1: begin mul_a = r_a1; mul_b = r_a1; end
            ST_SQ2: begin mul_a = r_a2; mul_b = r_a2; end
            ST_LOG: begin mul_a = r_z; mul_b = r_z; end
            ST_SCALE: begin mul_a = t_full[31:0]; mul_b = {4'd0, LN2_Q28}; end
            ST_SCALE_HI: begin mul_a = t_full[63:32]; mul_b = {4'd0, LN2_Q28}; end
            ST_MAG1: begin mul_a = r_a1; mul_b = r_sq; end
            ST_MAG2: begin mul_a = r_a2; mul_b = r_sq; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_normal_law) n_state = ST_UNI;
                    else if (r_spare_held) n_state = ST_DONE;
                    else n_state = ST_DRAW1;
                end
            end
            ST_UNI:   n_state = ST_DONE;
            ST_DRAW1: n_state = ST_DRAW2;
            ST_DRAW2: n_state = ST_SQ1;
            ST_SQ1:   n_state = ST_SQ2;
            ST_SQ2:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_acc == 64'd0 || r_acc > (64'd1 << 62)) n_state = ST_DRAW1;
                else n_state = ST_NORM;
            end
            ST_NORM:  if (r_acc[62]) n_state = ST_LOG;
            ST_LOG:   n_state = ST_LOG_FIX;
            ST_LOG_FIX: if (r_cnt == 5'd30) n_state = ST_SCALE;
                        else n_state = ST_LOG;
            ST_SCALE: n_state = ST_SCALE_HI;
            ST_SCALE_HI: n_state = ST_DIV;
            ST_DIV:   if (r_it == 7'd93) n_state = ST_SQRT;
            ST_SQRT:  if (r_it == 7'd31) n_state = ST_MAG1;
            ST_MAG1:  n_state = ST_MAG2;
            ST_MAG2:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg        <= '0;
            r_spare_held <= 1'b0;
            r_spare      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (out_acc) r_ovalid <= 1'b0;
            if (i_seed_value_we) begin
                r_lcg        <= i_seed_value;
                r_spare_held <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_normal_law && r_spare_held) begin
                        r_sample     <= r_spare;
                        r_spare_held <= 1'b0;
                    end
                end
                ST_UNI: begin
                    r_lcg    <= lcg_nx;
                    r_sample <= 32'({lcg_nx} >> (31 - FRAC_BITS));
                end
                ST_DRAW1: begin
                    r_lcg <= lcg_nx; r_a1 <= dmag; r_n1 <= dneg;
                end
                ST_DRAW2: begin
                    r_lcg <= lcg_nx; r_a2 <= dmag; r_n2 <= dneg;
                end
                ST_SQ1: r_acc <= mul_p;
                ST_SQ2: begin
                    r_acc <= r_acc + mul_p;
                    r_k   <= '0;
                end
                ST_NORM: begin
                    if (!r_acc[62]) begin
                        r_acc <= r_acc << 1;
                        r_k   <= r_k + 6'd1;
                    end else begin
                        r_yq  <= r_acc[63:32];
                        r_z   <= r_acc[63:32];
                        r_log <= '0;
                        r_cnt <= 5'd1;
                    end
                end
                ST_LOG: r_prod <= mul_p >> 30;
                ST_LOG_FIX: begin
                    if (r_prod >= 64'h8000_0000) begin
                        r_z <= r_prod[32:1];
                        r_log[5'd30 - r_cnt] <= 1'b1;
                    end else begin
                        r_z <= r_prod[31:0];
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                // low half of the log term times ln 2
                ST_SCALE: r_prod <= mul_p;
                ST_SCALE_HI: begin
                    r_num <= r_k[0] ? (a_q48 << 2) : (a_q48 << 1);
                    r_h   <= r_k[0] ? ((r_k - 6'd1) >> 1) : (r_k >> 1);
                    r_rem <= '0;
                    r_it  <= '0;
                end
                ST_DIV: begin
                    // restoring divide of num*2^30 by yq: 64 steps over num,
                    // then 30 steps shifting in zeros for the fraction
                    if (!dv_try[33]) begin
                        r_rem <= dv_try[32:0];
                        r_num <= {r_num[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_num[63]};
                        r_num <= {r_num[62:0], 1'b0};
                    end
                    // load root operand once divide completes
                    if (r_it == 7'd93) begin
                        r_qv   <= {r_num[62:0], !dv_try[33]};
                        r_sq   <= '0;
                        r_srem <= '0;
                        r_it   <= '0;
                    end else begin
                        r_it <= r_it + 7'd1;
                    end
                end
                ST_SQRT: begin
                    if (!sr_try[33]) begin
                        r_srem <= sr_try;
                        r_sq   <= {r_sq[30:0], 1'b1};
                    end else begin
                        r_srem <= sr_rem2;
                        r_sq   <= {r_sq[30:0], 1'b0};
                    end
                    r_qv <= r_qv << 2;
                    r_it <= r_it + 7'd1;
                end
                ST_MAG1: r_sample <= make_s(mul_p, r_n1, r_h);
                ST_MAG2: begin
                    r_spare      <= make_s(mul_p, r_n2, r_h);
                    r_spare_held <= 1'b1;
                end
                ST_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Assertions
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input taken while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_sample)))
        else $error("result dropped under stall");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_ovalid) else $error("done without result");
    a_spare_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAG2 && !i_seed_value_we) |=> r_spare_held)
        else $error("spare not cached");

endmodule

`default_nettype wire
